// ===== src/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg
// Types and constants shared by the ray/box slab test pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

  localparam int QW      = 32;   // width of every fixed point value
  localparam int DIFF_W  = 33;   // bound minus origin, exact
  localparam int NUM_AX  = 3;
  localparam int DIV_LAT = 33;   // overflow check, 31 quotient bits, sign fix

  localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_MAX_X = 3'd3,
    REG_MAX_Y = 3'd4,
    REG_MAX_Z = 3'd5
  } reg_idx_t;

  // per-request data that rides beside the dividers
  typedef struct packed {
    logic signed [QW-1:0] lo;
    logic signed [QW-1:0] hi;
    logic [NUM_AX-1:0]    zero_dir;
    logic                 miss;
  } side_t;

endpackage

`default_nettype wire

// ===== src/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div
// Pipelined sign-magnitude divider, one quotient bit per stage, with
// saturation of the quotient to the signed 32-bit range.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic                              neg,
  input  wire logic [rbst_pkg::DIFF_W+FRAC_BITS-1:0] num_mag,
  input  wire logic [rbst_pkg::QW-1:0]           den_mag,
  output logic signed [rbst_pkg::QW-1:0]         quo
);

  localparam int NW = rbst_pkg::DIFF_W + FRAC_BITS;
  localparam int QB = rbst_pkg::QW - 1;   // quotient bits below saturation

  logic [QB:0]   rem_r [0:QB];
  logic [QB-1:0] low_r [0:QB];
  logic [QB-1:0] quo_r [0:QB];
  logic [QB:0]   den_r [0:QB];
  logic          neg_r [0:QB];
  logic          ovf_r [0:QB];
  logic signed [rbst_pkg::QW-1:0] res_r, res_nxt;

  // quotient of 2^31 or more saturates either way
  always_ff @(posedge clk) begin
    if (en) begin
      ovf_r[0] <= (num_mag >> QB) >= NW'(den_mag);
      rem_r[0] <= (QB+1)'(num_mag >> QB);
      low_r[0] <= num_mag[QB-1:0];
      quo_r[0] <= '0;
      den_r[0] <= den_mag;
      neg_r[0] <= neg;
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [QB+1:0] trial;
    logic          ge;
    logic [QB:0]   rem_nxt;
    always_comb begin
      trial   = {rem_r[k-1], low_r[k-1][QB-1]};
      ge      = trial >= {1'b0, den_r[k-1]};
      rem_nxt = ge ? (QB+1)'(trial - {1'b0, den_r[k-1]}) : trial[QB:0];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        low_r[k] <= {low_r[k-1][QB-2:0], 1'b0};
        quo_r[k] <= {quo_r[k-1][QB-2:0], ge};
        den_r[k] <= den_r[k-1];
        neg_r[k] <= neg_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  always_comb begin
    if (ovf_r[QB]) begin
      res_nxt = neg_r[QB] ? rbst_pkg::Q_MIN : rbst_pkg::Q_MAX;
    end else if (neg_r[QB]) begin
      res_nxt = -$signed({1'b0, quo_r[QB]});
    end else begin
      res_nxt = $signed({1'b0, quo_r[QB]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign quo = res_r;

endmodule

`default_nettype wire

// ===== src/rbst_merge.sv =====
// ----------------------------------------------------------------------------
// rbst_merge
// Orders each slab pair, narrows the distance interval over three axes and
// forms the hit flag in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_merge (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        vld_in,
  input  wire logic signed [rbst_pkg::QW-1:0] qa [0:rbst_pkg::NUM_AX-1],
  input  wire logic signed [rbst_pkg::QW-1:0] qb [0:rbst_pkg::NUM_AX-1],
  input  wire rbst_pkg::side_t             side,
  output logic                             out_valid,
  output logic                             out_is_hit
);

  localparam int NA = rbst_pkg::NUM_AX;

  logic signed [rbst_pkg::QW-1:0] near_r [0:NA-1], far_r [0:NA-1];
  logic signed [rbst_pkg::QW-1:0] near_nxt [0:NA-1], far_nxt [0:NA-1];
  logic signed [rbst_pkg::QW-1:0] lo1_r, lo2_r, hi1_r, hi2_r, lo_r, hi_r;
  logic signed [rbst_pkg::QW-1:0] lo_m1_r, hi_m1_r;
  logic miss_m1_r, miss_m2_r, miss_m3_r;
  logic v1_r, v2_r, v3_r, v4_r, hit_r;

  // a zero-direction axis contributes a neutral pair
  always_comb begin
    for (int a = 0; a < NA; a++) begin
      if (side.zero_dir[a]) begin
        near_nxt[a] = rbst_pkg::Q_MIN;
        far_nxt[a]  = rbst_pkg::Q_MAX;
      end else if (qa[a] > qb[a]) begin
        near_nxt[a] = qb[a];
        far_nxt[a]  = qa[a];
      end else begin
        near_nxt[a] = qa[a];
        far_nxt[a]  = qb[a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r    <= near_nxt;
      far_r     <= far_nxt;
      lo_m1_r   <= side.lo;
      hi_m1_r   <= side.hi;
      miss_m1_r <= side.miss;
      lo1_r     <= (near_r[0] > lo_m1_r) ? near_r[0] : lo_m1_r;
      lo2_r     <= (near_r[1] > near_r[2]) ? near_r[1] : near_r[2];
      hi1_r     <= (far_r[0] < hi_m1_r) ? far_r[0] : hi_m1_r;
      hi2_r     <= (far_r[1] < far_r[2]) ? far_r[1] : far_r[2];
      miss_m2_r <= miss_m1_r;
      lo_r      <= (lo1_r > lo2_r) ? lo1_r : lo2_r;
      hi_r      <= (hi1_r < hi2_r) ? hi1_r : hi2_r;
      miss_m3_r <= miss_m2_r;
      hit_r     <= !miss_m3_r && (hi_r > lo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= vld_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid  = v4_r;
  assign out_is_hit = hit_r;

endmodule

`default_nettype wire

// ===== src/ray_box_slab_test_core.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_core
// Slab-method test of a ray against an axis-aligned box held in registers.
// ----------------------------------------------------------------------------
// pipeline: 2 front stages, the first loaded at the accept edge,
// 33-stage bit-per-stage dividers, 4 merge stages
// throughput: one request per cycle; the whole pipeline holds while a
// result waits on out_stall
// reset: synchronous active-low rst_n clears valid bits and box registers
`default_nettype none

module ray_box_slab_test_core #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [31:0] in_origin_x,
  input  wire logic signed [31:0] in_origin_y,
  input  wire logic signed [31:0] in_origin_z,
  input  wire logic signed [31:0] in_dir_x,
  input  wire logic signed [31:0] in_dir_y,
  input  wire logic signed [31:0] in_dir_z,
  input  wire logic signed [31:0] in_t_lower,
  input  wire logic signed [31:0] in_t_upper,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_is_hit,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  localparam int NA = rbst_pkg::NUM_AX;
  localparam int QW = rbst_pkg::QW;
  localparam int DW = rbst_pkg::DIFF_W;
  localparam int NW = DW + FRAC_BITS;
  localparam int DL = rbst_pkg::DIV_LAT;

  logic signed [QW-1:0] bmin_r [0:NA-1], bmax_r [0:NA-1];
  logic signed [QW-1:0] org [0:NA-1], dir [0:NA-1];
  logic en;

  // stage 1
  logic signed [DW-1:0] dmin_r [0:NA-1], dmax_r [0:NA-1];
  logic signed [QW-1:0] dir1_r [0:NA-1];
  rbst_pkg::side_t      side1_r, side1_nxt;
  logic                 v1_r;
  // stage 2
  logic [DW-1:0]        amin_r [0:NA-1], amax_r [0:NA-1];
  logic [QW-1:0]        adir_r [0:NA-1];
  logic                 nmin_r [0:NA-1], nmax_r [0:NA-1];
  rbst_pkg::side_t      side2_r;
  logic                 v2_r;
  // alongside the dividers
  rbst_pkg::side_t      dside_r [0:DL-1];
  logic                 dv_r [0:DL-1];
  logic signed [QW-1:0] qa [0:NA-1], qb [0:NA-1];

  assign en        = !out_valid || !out_stall;
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        bmin_r[a] <= '0;
        bmax_r[a] <= '0;
      end
    end else if (cfg_valid) begin
      case (rbst_pkg::reg_idx_t'(cfg_index))
        rbst_pkg::REG_MIN_X: bmin_r[0] <= cfg_data;
        rbst_pkg::REG_MIN_Y: bmin_r[1] <= cfg_data;
        rbst_pkg::REG_MIN_Z: bmin_r[2] <= cfg_data;
        rbst_pkg::REG_MAX_X: bmax_r[0] <= cfg_data;
        rbst_pkg::REG_MAX_Y: bmax_r[1] <= cfg_data;
        rbst_pkg::REG_MAX_Z: bmax_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  assign org[0] = in_origin_x;
  assign org[1] = in_origin_y;
  assign org[2] = in_origin_z;
  assign dir[0] = in_dir_x;
  assign dir[1] = in_dir_y;
  assign dir[2] = in_dir_z;

  always_comb begin
    side1_nxt.lo   = in_t_lower;
    side1_nxt.hi   = in_t_upper;
    side1_nxt.miss = 1'b0;
    for (int a = 0; a < NA; a++) begin
      side1_nxt.zero_dir[a] = (dir[a] == '0);
      // parallel ray outside its slab
      if (side1_nxt.zero_dir[a] && (org[a] < bmin_r[a] || org[a] > bmax_r[a])) begin
        side1_nxt.miss = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int a = 0; a < NA; a++) begin
        dmin_r[a] <= DW'(bmin_r[a]) - DW'(org[a]);
        dmax_r[a] <= DW'(bmax_r[a]) - DW'(org[a]);
        dir1_r[a] <= dir[a];
        nmin_r[a] <= dmin_r[a][DW-1] ^ dir1_r[a][QW-1];
        nmax_r[a] <= dmax_r[a][DW-1] ^ dir1_r[a][QW-1];
        amin_r[a] <= dmin_r[a][DW-1] ? DW'(-dmin_r[a]) : DW'(dmin_r[a]);
        amax_r[a] <= dmax_r[a][DW-1] ? DW'(-dmax_r[a]) : DW'(dmax_r[a]);
        adir_r[a] <= dir1_r[a][QW-1] ? QW'(-dir1_r[a]) : QW'(dir1_r[a]);
      end
      side1_r <= side1_nxt;
      side2_r <= side1_r;
      dside_r[0] <= side2_r;
      for (int i = 1; i < DL; i++) begin
        dside_r[i] <= dside_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      for (int i = 0; i < DL; i++) begin
        dv_r[i] <= 1'b0;
      end
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      dv_r[0] <= v2_r;
      for (int i = 1; i < DL; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_axis
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_min (
      .clk     (clk),
      .en      (en),
      .neg     (nmin_r[a]),
      .num_mag (NW'(amin_r[a]) << FRAC_BITS),
      .den_mag (adir_r[a]),
      .quo     (qa[a])
    );
    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_max (
      .clk     (clk),
      .en      (en),
      .neg     (nmax_r[a]),
      .num_mag (NW'(amax_r[a]) << FRAC_BITS),
      .den_mag (adir_r[a]),
      .quo     (qb[a])
    );
  end

  rbst_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .vld_in     (dv_r[DL-1]),
    .qa         (qa),
    .qb         (qb),
    .side       (dside_r[DL-1]),
    .out_valid  (out_valid),
    .out_is_hit (out_is_hit)
  );

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ray/box slab test: directed corner rays and
// random rays against several boxes, compared against a behavioral slab model.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  localparam int FRAC = 16;
  localparam int PIPE_LAT = 39;
  localparam int WD_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_origin_x = '0, in_origin_y = '0, in_origin_z = '0;
  logic signed [31:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic signed [31:0] in_t_lower = '0, in_t_upper = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_is_hit;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  always #2 clk = ~clk;

  ray_box_slab_test_core #(.FRAC_BITS(FRAC)) u_top (.*);

  typedef struct {
    logic signed [31:0] org [3];
    logic signed [31:0] dir [3];
    logic signed [31:0] t_lo;
    logic signed [31:0] t_hi;
  } ray_t;

  logic signed [31:0] box_lo [3];
  logic signed [31:0] box_hi [3];
  logic hit_q [$];
  int err_cnt = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  function automatic logic signed [31:0] slab_dist(logic signed [31:0] bound,
      logic signed [31:0] org, logic signed [31:0] dir);
    longint num;
    longint q;
    num = (longint'(bound) - longint'(org)) * (longint'(1) <<< FRAC);
    q = num / longint'(dir);
    if (q > longint'(rbst_pkg::Q_MAX)) q = longint'(rbst_pkg::Q_MAX);
    if (q < longint'(rbst_pkg::Q_MIN)) q = longint'(rbst_pkg::Q_MIN);
    return q[31:0];
  endfunction

  function automatic logic ray_hits_box(ray_t r);
    logic signed [31:0] lo, hi, a, b, nr, fr;
    logic ok;
    lo = r.t_lo;
    hi = r.t_hi;
    ok = 1'b1;
    for (int ax = 0; ax < 3; ax++) begin
      if (r.dir[ax] == 0) begin
        if (r.org[ax] < box_lo[ax] || r.org[ax] > box_hi[ax]) ok = 1'b0;
      end else begin
        a = slab_dist(box_lo[ax], r.org[ax], r.dir[ax]);
        b = slab_dist(box_hi[ax], r.org[ax], r.dir[ax]);
        nr = (a > b) ? b : a;
        fr = (a > b) ? a : b;
        if (nr > lo) lo = nr;
        if (fr < hi) hi = fr;
      end
    end
    if (hi <= lo) ok = 1'b0;
    return ok;
  endfunction

  // receiver: random stall and in-order compare
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (hit_q.size() == 0) begin
        $error("unexpected result is_hit=%0d", out_is_hit);
        err_cnt++;
      end else begin
        if (out_is_hit !== hit_q[0]) begin
          $error("is_hit expected %0d actual %0d", hit_q[0], out_is_hit);
          err_cnt++;
        end
        void'(hit_q.pop_front());
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // watchdog on cycles with no request or result moving
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_box(rbst_pkg::reg_idx_t idx, logic signed [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx < rbst_pkg::REG_MAX_X) box_lo[idx] = val;
    else box_hi[idx - rbst_pkg::REG_MAX_X] = val;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic set_box(logic signed [31:0] lx, ly, lz, hx, hy, hz);
    drain();
    write_box(rbst_pkg::REG_MIN_X, lx);
    write_box(rbst_pkg::REG_MIN_Y, ly);
    write_box(rbst_pkg::REG_MIN_Z, lz);
    write_box(rbst_pkg::REG_MAX_X, hx);
    write_box(rbst_pkg::REG_MAX_Y, hy);
    write_box(rbst_pkg::REG_MAX_Z, hz);
    cfg_valid <= 1'b0;
  endtask

  // leaves in_valid high after the accept; whoever waits next lowers it
  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_origin_x <= r.org[0];
    in_origin_y <= r.org[1];
    in_origin_z <= r.org[2];
    in_dir_x <= r.dir[0];
    in_dir_y <= r.dir[1];
    in_dir_z <= r.dir[2];
    in_t_lower <= r.t_lo;
    in_t_upper <= r.t_hi;
    do @(posedge clk); while (in_stall);
    hit_q.push_back(ray_hits_box(r));
  endtask

  function automatic logic signed [31:0] rand_val(int sel);
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return '0;
      3: return $urandom();
      default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  function automatic ray_t rand_ray();
    ray_t r;
    for (int ax = 0; ax < 3; ax++) begin
      r.org[ax] = rand_val($urandom_range(12));
      r.dir[ax] = ($urandom_range(9) == 0) ? 32'sd0 : rand_val($urandom_range(12));
      // mostly aim roughly toward the box so hits are common
      if ($urandom_range(3) != 0 && box_hi[ax] >= box_lo[ax])
        r.org[ax] = box_lo[ax] + 32'($urandom_range(32'(box_hi[ax] - box_lo[ax])));
    end
    r.t_lo = ($urandom_range(3) == 0) ? rand_val($urandom_range(12)) : 32'sh8000_0000;
    r.t_hi = ($urandom_range(3) == 0) ? rand_val($urandom_range(12)) : 32'sh7fff_ffff;
    return r;
  endfunction

  function automatic ray_t mk_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz, tl, th);
    ray_t r;
    r.org = '{ox, oy, oz};
    r.dir = '{dx, dy, dz};
    r.t_lo = tl;
    r.t_hi = th;
    return r;
  endfunction

  task automatic test_directed();
    localparam logic signed [31:0] ONE = 32'sh0001_0000;
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    send_ray(mk_ray(-5*ONE, 0, 0, ONE, 0, 0, 0, 100*ONE));        // plain hit
    send_ray(mk_ray(-5*ONE, 3*ONE, 0, ONE, 0, 0, 0, 100*ONE));    // zero dir outside
    send_ray(mk_ray(-5*ONE, ONE, -ONE, ONE, 0, 0, 0, 100*ONE));   // zero dir on edge
    send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, 5*ONE, 5*ONE));       // empty interval
    send_ray(mk_ray(0, 0, 0, ONE, ONE, ONE, 5*ONE, -ONE));        // inverted interval
    send_ray(mk_ray(0, 0, 0, 0, 0, 0, 0, ONE));                   // all zero dir inside
    send_ray(mk_ray(5*ONE, 0, 0, -ONE, 0, 0, 0, 100*ONE));        // negative dir
    send_ray(mk_ray(32'sh8000_0000, 0, 0, 1, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
    send_ray(mk_ray(32'sh7fff_ffff, 0, 0, 32'sh8000_0000, 0, 0, 0, 32'sh7fff_ffff));
    send_ray(mk_ray(32'sh7fff_ffff, 32'sh8000_0000, 0, -1, 32'sh7fff_ffff, 1,
                    32'sh8000_0000, 32'sh7fff_ffff));             // saturation
    send_ray(mk_ray(-3*ONE, 0, 0, ONE, 0, 0, 0, 2*ONE));          // exit before entry
    send_ray(mk_ray(-3*ONE, 0, 0, ONE, 0, 0, 4*ONE, 100*ONE));    // t_lower at box exit
    send_ray(mk_ray(-3*ONE, 0, 0, ONE, 0, 0, 2*ONE, 4*ONE));      // touching at entry
    // box inverted on x and z, and a zero dir on an inverted axis
    set_box(ONE, -ONE, ONE, -ONE, ONE, -ONE);
    send_ray(mk_ray(-5*ONE, 0, 0, ONE, 0, ONE, 32'sh8000_0000, 32'sh7fff_ffff));
    send_ray(mk_ray(-5*ONE, 0, 0, ONE, 0, 0, 32'sh8000_0000, 32'sh7fff_ffff));
    set_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
            32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff);
    send_ray(mk_ray(0, 0, 0, 1, 1, 1, 32'sh8000_0000, 32'sh7fff_ffff));
    send_ray(mk_ray(32'sh7fff_ffff, 32'sh8000_0000, 0, 0, 0, -1, 0, 1));
  endtask

  task automatic test_random_box(int n_rays);
    logic signed [31:0] c [3], h [3];
    for (int ax = 0; ax < 3; ax++) begin
      c[ax] = rand_val($urandom_range(3, 4));
      h[ax] = 32'($urandom_range(32'h0010_0000));
    end
    if ($urandom_range(4) == 0) set_box($urandom(), $urandom(), $urandom(),
                                       $urandom(), $urandom(), $urandom());
    else set_box(c[0] - h[0], c[1] - h[1], c[2] - h[2],
                 c[0] + h[0], c[1] + h[1], c[2] + h[2]);
    for (int i = 0; i < n_rays; i++) send_ray(rand_ray());
  endtask

  task automatic test_idle_phases();
    int pct [4][2] = '{'{0, 0}, '{61, 0}, '{0, 61}, '{9, 9}};
    for (int p = 0; p < 4; p++) begin
      idle_pct = pct[p][0];
      stall_pct = pct[p][1];
      for (int b = 0; b < 4; b++) test_random_box(100);
    end
    idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_pause_until_empty();
    test_random_box(60);
    // hold off until every outstanding request has returned
    in_valid <= 1'b0;
    while (hit_q.size() != 0) @(posedge clk);
    for (int i = 0; i < 60; i++) send_ray(rand_ray());
  endtask

  initial begin
    for (int ax = 0; ax < 3; ax++) begin
      box_lo[ax] = '0;
      box_hi[ax] = '0;
    end
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_idle_phases();
    test_pause_until_empty();
    drain();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
